### design/bytes_to_bech32_chars_unit_macros.svh
// Assertion macros for the bech32 character encoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BYTES_TO_BECH32_CHARS_UNIT_MACROS_SVH
`define BYTES_TO_BECH32_CHARS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B32C_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b32c check failed");

// Next-cycle implication, disabled during reset.
`define B32C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b32c check failed");

`endif

### design/b32c_pkg.sv
// Shared types and the bech32 alphabet for the bech32 character encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b32c_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       out_last;
   } rsp_payload_type;

   // carried leftover bits, right-aligned
   typedef struct packed {
      logic [3:0] bits;
      logic [2:0] count;
   } spare_type;

   // characters produced by one byte (1..3), last flag applies to the final one
   typedef struct packed {
      logic [2:0][6:0] chars;
      logic [1:0]      count;
      logic            last;
   } grp_type;

   // ASCII of "qpzry9x8gf2tvdw0s3jn54khce6mua7l"
   localparam logic [6:0] B32C_ALPHABET [32] = '{
      7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
      7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
      7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
      7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
   };

endpackage

`default_nettype wire

### design/b32c_regroup.sv
// Regroups one byte plus carried bits into 5-bit words and maps them to ASCII.
// Depends on b32c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32c_regroup
   import b32c_pkg::*;
(
   input  wire  spare_type       spare_i,
   input  wire  req_payload_type payload_i,
   output grp_type               grp_o,
   output spare_type             spare_next_o
);

   logic [2:0]  cnt;
   logic [3:0]  total;
   logic [11:0] acc_raw;
   logic [12:0] mask_full;
   logic [11:0] acc;
   logic        two;
   logic [3:0]  sh0;
   logic [3:0]  sh1;
   logic [11:0] acc_sh0;
   logic [11:0] acc_sh1;
   logic [4:0]  word0;
   logic [4:0]  word1;
   logic [3:0]  rem_w;
   logic [2:0]  rem;
   logic [11:0] acc_pad;
   logic [4:0]  pad_word;
   logic        pad_needed;
   logic [4:0]  mask4;

   always_comb begin
      cnt        = (spare_i.count > 3'd4) ? 3'd4 : spare_i.count;
      total      = {1'b0, cnt} + 4'd8;
      acc_raw    = {spare_i.bits, payload_i.data_byte};
      mask_full  = (13'd1 << total) - 13'd1;
      acc        = acc_raw & mask_full[11:0];
      two        = (total >= 4'd10);
      sh0        = total - 4'd5;
      sh1        = total - 4'd10;   // only meaningful when two words
      acc_sh0    = acc >> sh0;
      acc_sh1    = acc >> sh1;
      word0      = acc_sh0[4:0];
      word1      = acc_sh1[4:0];
      rem_w      = two ? sh1 : sh0;
      rem        = rem_w[2:0];
      // leftover bits left-aligned in a 5-bit word, zero padded
      acc_pad    = acc << (3'd5 - rem);
      pad_word   = acc_pad[4:0];
      pad_needed = payload_i.final_byte && (rem != 3'd0);
      mask4      = (5'd1 << rem) - 5'd1;

      grp_o.chars[0] = B32C_ALPHABET[word0];
      grp_o.chars[1] = two ? B32C_ALPHABET[word1] : B32C_ALPHABET[pad_word];
      grp_o.chars[2] = B32C_ALPHABET[pad_word];
      grp_o.count    = {1'b0, two} + 2'd1 + {1'b0, pad_needed};
      grp_o.last     = payload_i.final_byte;

      if (payload_i.final_byte) begin
         spare_next_o.bits  = 4'd0;
         spare_next_o.count = 3'd0;
      end else begin
         spare_next_o.bits  = acc[3:0] & mask4[3:0];
         spare_next_o.count = rem;
      end
   end

endmodule

`default_nettype wire

### design/bytes_to_bech32_chars_unit.sv
// Top level of the bech32 data-part character encoder (no prefix, no checksum).
// Depends on b32c_pkg, b32c_regroup and bytes_to_bech32_chars_unit_macros.svh.
//
//   channel | dir | beat contents                     | handshake
//   --------+-----+-----------------------------------+----------------------
//   req_    | in  | data_byte[7:0], final_byte        | req_valid / req_ready
//   rsp_    | out | out_char[6:0] ASCII, out_last     | rsp_valid / rsp_ready
//
// Flow: an accepted byte is regrouped in the cycle of acceptance into a
//   group of 1..3 characters, 1.6 on average; the group register then
//   issues one character per cycle into the output register while that
//   register is free or emptying, so the single-character output register
//   sets the pace.
// The next byte is taken in the cycle the group's final character moves to
//   the output register, so bytes flow with no bubble.
// Reset clears the carried bits, the group valid and index and the output
//   valid; no clearing pass. A stalled rsp_ready holds the output beat and,
//   once the group is waiting too, drops req_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "bytes_to_bech32_chars_unit_macros.svh"

module bytes_to_bech32_chars_unit
   import b32c_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_ready,
   input  wire  req_payload_type req_payload,
   output logic            rsp_valid,
   input  wire             rsp_ready,
   output rsp_payload_type rsp_payload
);

   // carried leftover bits between bytes
   spare_type       spare_ff, spare_in;

   // group of characters from the most recent byte
   grp_type         grp_ff, grp_in;
   logic            grp_valid_ff, grp_valid_in;
   logic [1:0]      grp_idx_ff, grp_idx_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   grp_type         grp_new;
   spare_type       spare_new;
   logic            load_out;
   logic            grp_final_char;
   logic            grp_done;
   logic            req_fire;

   b32c_regroup u_regroup (
      .spare_i      (spare_ff),
      .payload_i    (req_payload),
      .grp_o        (grp_new),
      .spare_next_o (spare_new)
   );

   // output register free or emptying this cycle -> move next char in
   assign load_out       = grp_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign grp_final_char = (grp_idx_ff == (grp_ff.count - 2'd1));
   assign grp_done       = load_out && grp_final_char;
   assign req_ready      = !grp_valid_ff || grp_done;
   assign req_fire       = req_valid && req_ready;

   always_comb begin
      spare_in       = spare_ff;
      grp_in         = grp_ff;
      grp_valid_in   = grp_valid_ff;
      grp_idx_in     = grp_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (req_fire) begin
         spare_in     = spare_new;
         grp_in       = grp_new;
         grp_valid_in = 1'b1;
         grp_idx_in   = 2'd0;
      end else if (grp_done) begin
         grp_valid_in = 1'b0;
      end else if (load_out) begin
         grp_idx_in   = grp_idx_ff + 2'd1;
      end

      if (load_out) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_char = grp_ff.chars[grp_idx_ff];
         rsp_payload_in.out_last = grp_ff.last && grp_final_char;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spare_ff     <= '0;
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spare_ff     <= spare_in;
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      grp_ff         <= grp_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // carried bit count stays within a partial word
   `B32C_ASSERT_NOW(a_spare_range, clock, reset, 1'b1, spare_ff.count <= 3'd4)
   // a live group always has a character left to issue
   `B32C_ASSERT_NOW(a_grp_idx, clock, reset, grp_valid_ff,
      (grp_ff.count != 2'd0) && (grp_idx_ff < grp_ff.count))
   // a final byte leaves no carry behind
   `B32C_ASSERT_NEXT(a_final_clears, clock, reset, req_fire && req_payload.final_byte,
      (spare_ff.count == 3'd0) && (spare_ff.bits == 4'd0))
   // an accepted byte starts a fresh group
   `B32C_ASSERT_NEXT(a_grp_load, clock, reset, req_fire,
      grp_valid_ff && (grp_idx_ff == 2'd0))

endmodule

`default_nettype wire

### bench/bytes_to_bech32_chars_unit_tb.sv
// Self-checking bench for bytes_to_bech32_chars_unit: random and directed byte messages,
// characters predicted in-bench and checked beat by beat under random back-pressure.
// Depends on b32c_pkg (beat types) and the RTL of the unit.
`timescale 1ns / 1ps

module bytes_to_bech32_chars_unit_tb
   import b32c_pkg::*;
();

   // bech32 alphabet, first character in the top byte
   localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam int DRAIN_LIMIT = 20000;   // cycles allowed for the output to empty
   localparam int TAIL_CYCLES = 12;      // quiet cycles after the last character

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   // byte source for the driver, characters awaiting the monitor
   req_payload_type pending_bytes[$];
   rsp_payload_type expected_chars[$];
   rsp_payload_type oldest_char;

   // bench copy of the carry between bytes
   logic [3:0] carry_bits = '0;
   logic [2:0] carry_count = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;

   bytes_to_bech32_chars_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [6:0] bech32_char(input int unsigned idx);
      logic [7:0] c;
      c = CHARSET[8 * (31 - idx) +: 8];
      return c[6:0];
   endfunction

   // Regroup one accepted byte with the carried bits into 5-bit words and
   // queue the characters it yields; the final byte flushes a padded word.
   task automatic encode_beat(input req_payload_type beat);
      int unsigned cnt;
      int unsigned acc;
      int unsigned total;
      int unsigned nwords;
      int unsigned rem;
      int unsigned word;
      rsp_payload_type ch;
      cnt = (carry_count > 4) ? 4 : carry_count;
      acc = {carry_bits, beat.data_byte};
      acc = acc & ((1 << (cnt + 8)) - 1);
      total = cnt + 8;
      nwords = total / 5;
      rem = total % 5;
      for (int unsigned i = 0; i < nwords; i++) begin
         word = (acc >> (total - 5 * (i + 1))) & 31;
         ch.out_char = bech32_char(word);
         // no leftover on the final byte: its last regular character ends the message
         ch.out_last = beat.final_byte && (rem == 0) && (i + 1 == nwords);
         expected_chars.push_back(ch);
      end
      if (beat.final_byte) begin
         if (rem > 0) begin
            // leftover bits left-aligned, zero-padded
            word = ((acc & ((1 << rem) - 1)) << (5 - rem)) & 31;
            ch.out_char = bech32_char(word);
            ch.out_last = 1'b1;
            expected_chars.push_back(ch);
         end
         carry_bits = '0;
         carry_count = '0;
      end else begin
         carry_bits = 4'(acc & ((1 << rem) - 1));
         carry_count = 3'(rem);
      end
   endtask

   // Driver: holds a beat until accepted, then maybe idles before the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) encode_beat(req_payload);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted character against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual char %h last %b",
                        $time, rsp_payload.out_char, rsp_payload.out_last);
               mismatch_count++;
            end else begin
               oldest_char = expected_chars.pop_front();
               if (rsp_payload.out_char !== oldest_char.out_char) begin
                  $display("%0t: out_char mismatch, expected %h actual %h",
                           $time, oldest_char.out_char, rsp_payload.out_char);
                  mismatch_count++;
               end
               if (rsp_payload.out_last !== oldest_char.out_last) begin
                  $display("%0t: out_last mismatch, expected %b actual %b",
                           $time, oldest_char.out_last, rsp_payload.out_last);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic push_byte(input logic [7:0] data, input logic fin);
      req_payload_type beat;
      beat.data_byte = data;
      beat.final_byte = fin;
      pending_bytes.push_back(beat);
   endtask

   // Whole messages of random bytes; mostly short, some long runs of carry.
   task automatic fill_random(input int count);
      int queued;
      int len;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 99) < 80) len = $urandom_range(1, 8);
         else len = $urandom_range(9, 24);
         for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)), i == len - 1);
         end
         queued += len;
      end
   endtask

   // Sender pause: nothing new until every queued character has come back.
   task automatic wait_drain();
      int cycles;
      cycles = 0;
      while ((pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0)
             && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (expected_chars.size() != 0) begin
         $display("%0t: %0d characters never arrived, next expected char %h last %b",
                  $time, expected_chars.size(), expected_chars[0].out_char,
                  expected_chars[0].out_last);
         mismatch_count++;
         expected_chars.delete();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver stalls often
      send_idle_pct = 16;
      recv_idle_pct = 55;
      // final byte at every carry depth 0, 3, 1, 4, 2; extremes of the data
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b1);     // carry of 4 bits: three characters
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(8'h33, 1'b0);
      push_byte(8'hCC, 1'b1);     // carry of 2 bits: no pad, regular char ends it
      for (int i = 0; i < 5; i++) push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);     // carry back to zero before the final byte
      wait_drain();
      fill_random(50);
      wait_drain();
      fill_random(50);
      wait_drain();

      // phase 2: roles swapped
      send_idle_pct = 55;
      recv_idle_pct = 16;
      fill_random(90);
      wait_drain();

      // phase 3: full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_random(90);
      wait_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
